// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define AHRC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define AHRC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define AHRC_ASSERT(lbl, clk, rst, prop, msg)
`define AHRC_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== rtl/core/ahrc_pkg.sv =====
package ahrc_pkg;

  localparam int AGE_BINS    = 128;
  localparam int COUNT_WIDTH = 32;
  localparam int AGE_W       = 7;
  localparam int OUT_W       = 32;
  localparam int IDX_W       = $clog2(AGE_BINS);
  localparam int SUM_W       = ((COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W) + 1;

  localparam logic [OUT_W-1:0]       OUT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic {
    MODE_RECORD = 1'b0,
    MODE_QUERY  = 1'b1
  } ahrc_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_Q_RD,
    ST_Q_TAIL,
    ST_Q_DONE
  } ahrc_state_t;

  function automatic logic [IDX_W-1:0] to_idx(input logic [AGE_W-1:0] a);
    logic [31:0] t;
    t = 32'(a);
    return t[IDX_W-1:0];
  endfunction

  function automatic logic in_range(input logic [AGE_W-1:0] a);
    return 32'(a) < 32'(AGE_BINS);
  endfunction

endpackage

// ===== rtl/core/ahrc_req_if.sv =====
interface ahrc_req_if import ahrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [AGE_W-1:0] age;
  logic [AGE_W-1:0] min_age;
  logic [AGE_W-1:0] max_age;

  modport source (output valid, mode, age, min_age, max_age, input ready);
  modport sink   (input valid, mode, age, min_age, max_age, output ready);
endinterface

// ===== rtl/core/ahrc_rsp_if.sv =====
interface ahrc_rsp_if import ahrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] range_count;

  modport source (output valid, range_count, input ready);
  modport sink   (input valid, range_count, output ready);
endinterface

// ===== rtl/core/age_histogram_range_count.sv =====
// channel | dir | payload                          | words
// req     | in  | mode, age, min_age, max_age      | one per item
// rsp     | out | range_count                      | one per query, none per record
//
// record: accept, bin read, bin write back; an age past the last bin is dropped
// query: reads each bin from lo to hi with hi clamped to the last bin, one bin read per
//   cycle through the single memory read port; an empty range goes straight to done
// rst clears all per-bin valid flags together, no clearing pass
// a finished query waits in its last state while an earlier rsp word is not taken;
//   req is taken only when the sequencer is idle
`include "assert_macros.svh"

module age_histogram_range_count import ahrc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  ahrc_req_if.sink        req,
  ahrc_rsp_if.source      rsp
);

  ahrc_state_t state, state_next;

  logic [COUNT_WIDTH-1:0] mem [AGE_BINS];
  logic [AGE_BINS-1:0]    vbit;

  logic [IDX_W-1:0]       addr;
  logic [IDX_W-1:0]       last;
  logic [OUT_W-1:0]       sum;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_hit;
  logic                   rd_pend;

  logic                   accept;
  logic                   rd_go;
  logic                   wr_go;
  logic                   out_load;
  logic                   slot_free;

  logic [AGE_W-1:0]       hi_clamp;
  logic                   q_nonempty;
  logic [COUNT_WIDTH-1:0] rd_val;
  logic [COUNT_WIDTH-1:0] inc_val;
  logic [SUM_W-1:0]       wide;
  logic [OUT_W-1:0]       sum_add;

  assign accept    = req.valid && req.ready;
  assign slot_free = !rsp.valid || rsp.ready;

  assign hi_clamp   = in_range(req.max_age) ? req.max_age : AGE_W'(AGE_BINS - 1);
  assign q_nonempty = in_range(req.min_age) && (req.min_age <= hi_clamp);

  assign rd_val  = rd_hit ? rd_data : '0;
  assign inc_val = (rd_val == CNT_MAX) ? rd_val : rd_val + COUNT_WIDTH'(1);
  assign wide    = SUM_W'(sum) + SUM_W'(rd_val);
  assign sum_add = (wide >= SUM_W'(OUT_MAX)) ? OUT_MAX : wide[OUT_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_RECORD) begin
            if (in_range(req.age)) state_next = ST_INS_RD;
          end else if (q_nonempty) begin
            state_next = ST_Q_RD;
          end else begin
            state_next = ST_Q_DONE;
          end
        end
      end
      ST_INS_RD: state_next = ST_INS_WR;
      ST_INS_WR: state_next = ST_IDLE;
      ST_Q_RD:   if (addr == last) state_next = ST_Q_TAIL;
      ST_Q_TAIL: state_next = ST_Q_DONE;
      ST_Q_DONE: if (slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    rd_go     = 1'b0;
    wr_go     = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:   req.ready = 1'b1;
      ST_INS_RD: rd_go = 1'b1;
      ST_INS_WR: wr_go = 1'b1;
      ST_Q_RD:   rd_go = 1'b1;
      ST_Q_TAIL: ;
      ST_Q_DONE: out_load = slot_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vbit      <= '0;
      rd_pend   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_Q_RD);
      if (wr_go) vbit[addr] <= 1'b1;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // bin store
  always_ff @(posedge clk) begin
    if (wr_go) mem[addr] <= inc_val;
    if (rd_go) begin
      rd_data <= mem[addr];
      rd_hit  <= vbit[addr];
    end
  end

  // address walk and running sum
  always_ff @(posedge clk) begin
    if (accept) begin
      sum <= '0;
      if (req.mode == MODE_RECORD) begin
        addr <= to_idx(req.age);
      end else begin
        addr <= to_idx(req.min_age);
        last <= to_idx(hi_clamp);
      end
    end else begin
      if (state == ST_Q_RD && addr != last) addr <= addr + IDX_W'(1);
      if (rd_pend) sum <= sum_add;
    end
    if (out_load) rsp.range_count <= sum;
  end

  `AHRC_ASSERT(a_walk_bound, clk, rst, (state == ST_Q_RD) |-> (addr <= last), "bin walk passed its end")
  `AHRC_ASSERT(a_wr_after_rd, clk, rst, (state == ST_INS_WR) |-> ($past(state) == ST_INS_RD), "bin write without read")
  `AHRC_ASSERT(a_rsp_src, clk, rst, $rose(rsp.valid) |-> ($past(state) == ST_Q_DONE), "rsp word without query")
  `AHRC_ASSERT(a_tail_done, clk, rst, (state == ST_Q_TAIL) |=> (state == ST_Q_DONE), "query tail did not finish")

endmodule
